FILE: rtl/core/lbb_pkg.sv
// Shared types and constants of the label bounding box block.
// No dependencies; the interfaces and the top level import this package.
`default_nettype none

package lbb_pkg;

	// Payload widths of the request, result and configuration words.
	localparam int OPCODE_W   = 1;
	localparam int LABEL_W    = 10;
	localparam int COORD_W    = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int FRAME_W    = 13;
	localparam int COUNT_W    = 11;

	// Request opcodes.
	localparam logic [OPCODE_W-1:0] OP_PIXEL = 1'b0;
	localparam logic [OPCODE_W-1:0] OP_READ  = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LABEL_COUNT  = 2'd2;

	// Register reset values.
	localparam logic [FRAME_W-1:0] FRAME_WIDTH_RST  = 13'd640;
	localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RST = 13'd480;
	localparam logic [COUNT_W-1:0] LABEL_COUNT_RST  = 11'd1024;

	// Frame epoch tag kept with every table entry. Tag zero marks a swept entry.
	localparam int EPOCH_W = 16;
	localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;
	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 16'd1;
	localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

endpackage

`default_nettype wire

FILE: rtl/core/lbb_if.sv
// Handshake channel interfaces of the label bounding box block.
// Depends on lbb_pkg for the payload widths.
`default_nettype none

interface lbb_req_if import lbb_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [LABEL_W-1:0]  label;

	modport source (output valid, output opcode, output label, input ready);
	modport sink   (input valid, input opcode, input label, output ready);
endinterface

interface lbb_rsp_if import lbb_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [LABEL_W-1:0] box_label;
	logic [COORD_W-1:0] min_x;
	logic [COORD_W-1:0] min_y;
	logic [COORD_W-1:0] max_x;
	logic [COORD_W-1:0] max_y;
	logic               present;

	modport source (output valid, output box_label, output min_x, output min_y,
		output max_x, output max_y, output present, input ready);
	modport sink   (input valid, input box_label, input min_x, input min_y,
		input max_x, input max_y, input present, output ready);
endinterface

interface lbb_cfg_if import lbb_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/label_bounding_box.sv
// Label bounding box: one request word per cycle, pixels and box reads mixed freely.
// A box read presents its result word through the table read and then the output
// register; pixels return nothing. A read that finds the output register
// still full waits in the pipeline and holds off further words until it is taken.
// After reset, and whenever the 16-bit frame epoch wraps (once in 65535 frames), a
// sweep clears every table entry while requests are held off.
// Configuration registers reset to 640 x 480 pixels and 1024 labels.
`default_nettype none

module label_bounding_box import lbb_pkg::*; #(
	parameter int MAX_LABELS = 1024,
	parameter int MAX_DIM    = 4096
) (
	input wire logic  clk,
	input wire logic  arst_n,
	lbb_req_if.sink   req,
	lbb_rsp_if.source rsp,
	lbb_cfg_if.sink   cfg
);

	// Address width of the table and coordinate widths that follow from the
	// largest frame. DIM_W can hold the frame size itself.
	localparam int LBL_W = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
	localparam int CRD_W = $clog2(MAX_DIM);
	localparam int DIM_W = CRD_W + 1;

	// One table entry: the frame epoch in which it was last written and the box.
	typedef struct packed {
		logic [EPOCH_W-1:0] tag;
		logic [CRD_W-1:0]   min_x;
		logic [CRD_W-1:0]   min_y;
		logic [CRD_W-1:0]   max_x;
		logic [CRD_W-1:0]   max_y;
	} entry_t;

	// Configuration registers. The port never stalls.
	logic [FRAME_W-1:0] frame_width_q;
	logic [FRAME_W-1:0] frame_height_q;
	logic [COUNT_W-1:0] label_count_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
			label_count_q  <= LABEL_COUNT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_FRAME_WIDTH:  frame_width_q  <= FRAME_W'(cfg.data);
				CFG_FRAME_HEIGHT: frame_height_q <= FRAME_W'(cfg.data);
				CFG_LABEL_COUNT:  label_count_q  <= COUNT_W'(cfg.data);
				default: begin
				end
			endcase
		end
	end

	// The frame size in use is clamped to 1..MAX_DIM.
	logic [DIM_W-1:0] w_eff;
	logic [DIM_W-1:0] h_eff;

	always_comb begin
		if (frame_width_q == '0) begin
			w_eff = DIM_W'(1);
		end else if (32'(frame_width_q) > MAX_DIM) begin
			w_eff = DIM_W'(MAX_DIM);
		end else begin
			w_eff = DIM_W'(frame_width_q);
		end
		if (frame_height_q == '0) begin
			h_eff = DIM_W'(1);
		end else if (32'(frame_height_q) > MAX_DIM) begin
			h_eff = DIM_W'(MAX_DIM);
		end else begin
			h_eff = DIM_W'(frame_height_q);
		end
	end

	// Raster position of the next pixel.
	logic [CRD_W-1:0] pos_x;
	logic [CRD_W-1:0] pos_y;
	logic             frame_start;
	logic             accept;
	logic             pixel_accept;

	lbb_raster_pos #(
		.CRD_W (CRD_W),
		.DIM_W (DIM_W)
	) u_raster_pos (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (pixel_accept),
		.frame_w     (w_eff),
		.frame_h     (h_eff),
		.x           (pos_x),
		.y           (pos_y),
		.frame_start (frame_start)
	);

	// Presence is tracked by a frame epoch rather than a bit per label. An entry
	// counts as present only if its tag equals the epoch of the current frame, so
	// starting a frame is just an increment. Tag zero is never a live epoch; when
	// the epoch runs out, the whole table is swept back to tag zero and the
	// epoch restarts at one, so no stale tag can ever alias a new frame.
	logic [EPOCH_W-1:0] epoch_q;
	logic [EPOCH_W-1:0] epoch_next;
	logic               epoch_wrap;

	assign epoch_wrap = pixel_accept && frame_start && (epoch_q == EPOCH_LAST);

	always_comb begin
		epoch_next = epoch_q;
		if (req.opcode == OP_PIXEL && frame_start) begin
			epoch_next = (epoch_q == EPOCH_LAST) ? EPOCH_FIRST : epoch_q + EPOCH_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q <= EPOCH_FIRST;
		end else if (accept) begin
			epoch_q <= epoch_next;
		end
	end

	// Sweep that writes tag zero into every entry; runs after reset and on a
	// wrap of the epoch. Requests are held off while it runs.
	logic             clearing_q;
	logic [LBL_W-1:0] clr_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			clr_idx_q <= clr_idx_q + LBL_W'(1);
			if (clr_idx_q == LBL_W'(MAX_LABELS - 1)) begin
				clearing_q <= 1'b0;
			end
		end else if (epoch_wrap) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end
	end

	// Stage one: the request waits here while its table entry is read.
	logic                valid_s1;
	logic [OPCODE_W-1:0] op_s1;
	logic [LABEL_W-1:0]  label_s1;
	logic [LBL_W-1:0]    addr_s1;
	logic                in_range_s1;
	logic                fresh_s1;
	logic [CRD_W-1:0]    x_s1;
	logic [CRD_W-1:0]    y_s1;
	logic [EPOCH_W-1:0]  epoch_s1;

	logic out_valid_q;
	logic out_free;
	logic s1_go;
	logic in_range;

	// A label at or above the label count, or beyond the table, is ignored.
	assign in_range = (32'(req.label) < 32'(label_count_q)) && (32'(req.label) < MAX_LABELS);

	assign out_free     = !out_valid_q || rsp.ready;
	assign s1_go        = valid_s1 && !clearing_q && (op_s1 == OP_PIXEL || out_free);
	assign req.ready    = !clearing_q && (!valid_s1 || s1_go);
	assign accept       = req.valid && req.ready;
	assign pixel_accept = accept && (req.opcode == OP_PIXEL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	// The first pixel of a frame always starts its entry afresh; this also
	// covers the pixel that triggered a sweep, whose table read is stale.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1       <= req.opcode;
			label_s1    <= req.label;
			addr_s1     <= LBL_W'(req.label);
			in_range_s1 <= in_range;
			fresh_s1    <= (req.opcode == OP_PIXEL) && frame_start;
			x_s1        <= pos_x;
			y_s1        <= pos_y;
			epoch_s1    <= epoch_next;
		end
	end

	// Box table with one write and one registered read per cycle.
	entry_t           box_mem [MAX_LABELS];
	entry_t           rdata_q;
	entry_t           cur;
	entry_t           upd;
	logic             present;
	logic             pix_wr;

	// Forwarding register: the most recent pixel write. A request accepted on the
	// same edge as that write read the old word, so the held copy wins on a match;
	// for any older write the copy equals the memory word anyway.
	logic             fwd_valid_q;
	logic [LBL_W-1:0] fwd_addr_q;
	entry_t           fwd_data_q;

	assign cur     = (fwd_valid_q && fwd_addr_q == addr_s1) ? fwd_data_q : rdata_q;
	assign present = in_range_s1 && !fresh_s1 && (cur.tag == epoch_s1);
	assign pix_wr  = s1_go && (op_s1 == OP_PIXEL) && in_range_s1;

	always_comb begin
		upd.tag = epoch_s1;
		if (present) begin
			upd.min_x = (x_s1 < cur.min_x) ? x_s1 : cur.min_x;
			upd.min_y = (y_s1 < cur.min_y) ? y_s1 : cur.min_y;
			upd.max_x = (x_s1 > cur.max_x) ? x_s1 : cur.max_x;
			upd.max_y = (y_s1 > cur.max_y) ? y_s1 : cur.max_y;
		end else begin
			upd.min_x = x_s1;
			upd.min_y = y_s1;
			upd.max_x = x_s1;
			upd.max_y = y_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			box_mem[clr_idx_q] <= '{tag: EPOCH_NONE, default: '0};
		end else if (pix_wr) begin
			box_mem[addr_s1] <= upd;
		end
		if (accept) begin
			rdata_q <= box_mem[LBL_W'(req.label)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (clearing_q) begin
			fwd_valid_q <= 1'b0;
		end else if (pix_wr) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_wr) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= upd;
		end
	end

	// Output register. A label absent from the frame reads as the initial box.
	logic [LABEL_W-1:0] box_label_q;
	logic [COORD_W-1:0] min_x_q;
	logic [COORD_W-1:0] min_y_q;
	logic [COORD_W-1:0] max_x_q;
	logic [COORD_W-1:0] max_y_q;
	logic               present_q;
	logic               rd_done;

	assign rd_done = s1_go && (op_s1 == OP_READ);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rd_done) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_done) begin
			box_label_q <= label_s1;
			present_q   <= present;
			if (present) begin
				min_x_q <= COORD_W'(cur.min_x);
				min_y_q <= COORD_W'(cur.min_y);
				max_x_q <= COORD_W'(cur.max_x);
				max_y_q <= COORD_W'(cur.max_y);
			end else begin
				min_x_q <= COORD_W'(w_eff - DIM_W'(1));
				min_y_q <= COORD_W'(h_eff - DIM_W'(1));
				max_x_q <= '0;
				max_y_q <= '0;
			end
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.box_label = box_label_q;
	assign rsp.min_x     = min_x_q;
	assign rsp.min_y     = min_y_q;
	assign rsp.max_x     = max_x_q;
	assign rsp.max_y     = max_y_q;
	assign rsp.present   = present_q;

endmodule

`default_nettype wire

FILE: rtl/core/lbb_raster_pos.sv
// Column and row counters of the raster pixel stream.
// Depends on nothing but the widths handed down by the top level.
`default_nettype none

module lbb_raster_pos #(
	parameter int CRD_W = 12,
	parameter int DIM_W = 13
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             advance,
	input  wire logic [DIM_W-1:0] frame_w,
	input  wire logic [DIM_W-1:0] frame_h,
	output logic      [CRD_W-1:0] x,
	output logic      [CRD_W-1:0] y,
	output logic                  frame_start
);

	logic [CRD_W-1:0] x_q;
	logic [CRD_W-1:0] y_q;
	logic [DIM_W-1:0] x_inc;
	logic [DIM_W-1:0] y_inc;

	assign x_inc = {1'b0, x_q} + DIM_W'(1);
	assign y_inc = {1'b0, y_q} + DIM_W'(1);

	// A counter left beyond a shrunken frame size wraps on its next advance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
		end else if (advance) begin
			if (x_inc >= frame_w) begin
				x_q <= '0;
				y_q <= (y_inc >= frame_h) ? '0 : CRD_W'(y_inc);
			end else begin
				x_q <= CRD_W'(x_inc);
			end
		end
	end

	assign x           = x_q;
	assign y           = y_q;
	assign frame_start = (x_q == '0) && (y_q == '0);

endmodule

`default_nettype wire
